// ----- sv/wss_pkg.sv -----
// Shared types and constants for the windowed series statistics block.
// No dependencies; used by every module of the block.
package wss_pkg;

	localparam int VALUE_BITS = 24;
	localparam int TIME_BITS  = 48;
	localparam int FRAC_BITS  = 8;
	localparam int CNT_BITS   = 17;
	localparam int SUM_BITS   = 41;
	localparam int SQ_BITS    = 63;
	localparam int ABS_BITS   = 40;
	localparam int OUT_BITS   = 31;
	localparam int MEAN_BITS  = 32;
	localparam int IVL_BITS   = 56;
	localparam int NUM_BITS   = 80;
	localparam int RAD_BITS   = 64;
	localparam int ROOT_BITS  = 32;
	localparam int DIV_CNT_BITS = 7;
	localparam int SQRT_CNT_BITS = 6;

	localparam logic [CNT_BITS-1:0] MAX_SAMPLES = 17'd65536;
	localparam logic [OUT_BITS-1:0] CAP31 = '1;

	// configuration register indexes
	localparam logic [1:0] CFG_ENABLE = 2'd0;
	localparam logic [1:0] CFG_START  = 2'd1;
	localparam logic [1:0] CFG_END    = 2'd2;

	// accumulated state of one finished series
	typedef struct packed {
		logic [CNT_BITS-1:0]          count;
		logic signed [VALUE_BITS-1:0] vmin;
		logic signed [VALUE_BITS-1:0] vmax;
		logic [TIME_BITS-1:0]         first_t;
		logic [TIME_BITS-1:0]         latest_t;
		logic signed [SUM_BITS-1:0]   vsum;
		logic [SQ_BITS-1:0]           ssum;
		logic [ABS_BITS-1:0]          asum;
		logic                         dropped;
	} snap_t;

endpackage

// ----- sv/wss_front.sv -----
// Front end: configuration registers, window classification and per-sample accumulation.
// Pushes a snapshot of the series into the queue on the last sample. Uses wss_pkg.
module wss_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [wss_pkg::TIME_BITS-1:0]         sample_time,
	input  logic signed [wss_pkg::VALUE_BITS-1:0] sample_value,
	input  logic                                  last_sample,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [1:0]                            cfg_index,
	input  logic [wss_pkg::TIME_BITS-1:0]         cfg_data,
	output logic                                  push,
	output wss_pkg::snap_t                        push_data,
	input  logic                                  full
);

	logic                          en_q;
	logic [wss_pkg::TIME_BITS-1:0] start_q;
	logic [wss_pkg::TIME_BITS-1:0] end_q;
	wss_pkg::snap_t                acc_q;
	logic                          past_q;

	wss_pkg::snap_t                 nxt;
	logic                           incl;
	logic                           past_nxt;
	logic                           take;
	logic                           accept;
	logic [wss_pkg::VALUE_BITS-1:0] mag;
	logic [2*wss_pkg::VALUE_BITS-1:0] sq;

	assign cfg_ready = 1'b1;
	assign in_ready  = !full;
	assign accept    = in_valid && in_ready;
	assign push      = accept && last_sample;
	assign push_data = nxt;

	assign mag = sample_value[wss_pkg::VALUE_BITS-1] ? (~sample_value + 1'b1) : sample_value;
	assign sq  = mag * mag;

	always_comb begin
		incl     = 1'b1;
		past_nxt = past_q;
		if (en_q) begin
			if (past_q) begin
				incl = 1'b0;
			end else if (sample_time < start_q) begin
				incl = 1'b0;
			end else if (sample_time > end_q) begin
				incl     = 1'b0;
				past_nxt = 1'b1;
			end
		end
		take = incl && (acc_q.count < wss_pkg::MAX_SAMPLES);
		nxt  = acc_q;
		if (incl && !take) begin
			nxt.dropped = 1'b1;
		end
		if (take) begin
			if (acc_q.count == '0) begin
				nxt.first_t  = sample_time;
				nxt.latest_t = sample_time;
				nxt.vmin     = sample_value;
				nxt.vmax     = sample_value;
			end else begin
				if (sample_time < acc_q.first_t) nxt.first_t = sample_time;
				if (sample_time > acc_q.latest_t) nxt.latest_t = sample_time;
				if (sample_value < acc_q.vmin) nxt.vmin = sample_value;
				if (sample_value > acc_q.vmax) nxt.vmax = sample_value;
			end
			nxt.count = acc_q.count + 1'b1;
			nxt.vsum  = acc_q.vsum + wss_pkg::SUM_BITS'(sample_value);
			nxt.ssum  = acc_q.ssum + wss_pkg::SQ_BITS'(sq);
			nxt.asum  = acc_q.asum + wss_pkg::ABS_BITS'(mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q    <= 1'b1;
			start_q <= '0;
			end_q   <= '1;
			acc_q   <= '0;
			past_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					wss_pkg::CFG_ENABLE: en_q    <= cfg_data[0];
					wss_pkg::CFG_START:  start_q <= cfg_data;
					wss_pkg::CFG_END:    end_q   <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				if (last_sample) begin
					acc_q  <= '0;
					past_q <= 1'b0;
				end else begin
					acc_q  <= nxt;
					past_q <= past_nxt;
				end
			end
		end
	end

endmodule

// ----- sv/wss_fifo.sv -----
// Two-entry queue of series snapshots between front and back end.
// Uses wss_pkg::snap_t.
module wss_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wss_pkg::snap_t push_data,
	input  logic           pop,
	output wss_pkg::snap_t pop_data,
	output logic           full,
	output logic           empty
);

	wss_pkg::snap_t mem_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue push while full");
	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue pop while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");

endmodule

// ----- sv/wss_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Denominator zero yields garbage; callers never issue it. Uses wss_pkg.
module wss_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [wss_pkg::NUM_BITS-1:0]   num,
	input  logic [wss_pkg::CNT_BITS-1:0]   den,
	output logic                           done,
	output logic [wss_pkg::NUM_BITS-1:0]   quot
);

	logic [wss_pkg::DIV_CNT_BITS-1:0] cnt_q;
	logic [wss_pkg::NUM_BITS-1:0]     num_q;
	logic [wss_pkg::CNT_BITS-1:0]     den_q;
	logic [wss_pkg::CNT_BITS-1:0]     rem_q;
	logic [wss_pkg::NUM_BITS-1:0]     quot_q;
	logic                             done_q;
	logic [wss_pkg::CNT_BITS:0]       rem_sh;
	logic                             ge;

	assign rem_sh = {rem_q, num_q[wss_pkg::NUM_BITS-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign done   = done_q;
	assign quot   = quot_q;

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q  <= num_q << 1;
			rem_q  <= ge ? wss_pkg::CNT_BITS'(rem_sh - {1'b0, den_q})
			             : wss_pkg::CNT_BITS'(rem_sh);
			quot_q <= {quot_q[wss_pkg::NUM_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == wss_pkg::DIV_CNT_BITS'(1));
			if (start) cnt_q <= wss_pkg::DIV_CNT_BITS'(wss_pkg::NUM_BITS);
			else if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- sv/wss_sqrt.sv -----
// Digit-by-digit integer square root, two radicand bits per cycle.
// Gives the floor of the exact root. Uses wss_pkg.
module wss_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wss_pkg::RAD_BITS-1:0]  x,
	output logic                          done,
	output logic [wss_pkg::ROOT_BITS-1:0] root
);

	logic [wss_pkg::SQRT_CNT_BITS-1:0] cnt_q;
	logic [wss_pkg::RAD_BITS-1:0]      x_q;
	logic [wss_pkg::ROOT_BITS+3:0]     rem_q;
	logic [wss_pkg::ROOT_BITS-1:0]     root_q;
	logic                              done_q;
	logic [wss_pkg::ROOT_BITS+3:0]     rem_sh;
	logic [wss_pkg::ROOT_BITS+3:0]     trial;
	logic                              ge;

	assign rem_sh = {rem_q[wss_pkg::ROOT_BITS+1:0], x_q[wss_pkg::RAD_BITS-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;
	assign done   = done_q;
	assign root   = root_q;

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			x_q    <= x_q << 2;
			rem_q  <= ge ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[wss_pkg::ROOT_BITS-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == wss_pkg::SQRT_CNT_BITS'(1));
			if (start) cnt_q <= wss_pkg::SQRT_CNT_BITS'(wss_pkg::ROOT_BITS);
			else if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- sv/wss_back.sv -----
// Back end: sequencer that turns one series snapshot into the result using
// the shared divider and square-root units. Uses wss_pkg, wss_div, wss_sqrt.
module wss_back (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   empty,
	input  wss_pkg::snap_t                         pop_data,
	output logic                                   pop,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [wss_pkg::CNT_BITS-1:0]           sample_count,
	output logic signed [wss_pkg::VALUE_BITS-1:0]  min_value,
	output logic signed [wss_pkg::VALUE_BITS-1:0]  max_value,
	output logic [wss_pkg::VALUE_BITS-1:0]         value_span,
	output logic signed [wss_pkg::MEAN_BITS-1:0]   mean_value,
	output logic [wss_pkg::OUT_BITS-1:0]           rms_value,
	output logic [wss_pkg::OUT_BITS-1:0]           std_deviation,
	output logic [wss_pkg::OUT_BITS-1:0]           abs_mean,
	output logic [wss_pkg::IVL_BITS-1:0]           sample_spacing,
	output logic                                   count_overflow
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_MEAN = 4'd1;
	localparam logic [3:0] S_MSQ  = 4'd2;
	localparam logic [3:0] S_ABS  = 4'd3;
	localparam logic [3:0] S_IVL  = 4'd4;
	localparam logic [3:0] S_MUL  = 4'd5;
	localparam logic [3:0] S_RMS  = 4'd6;
	localparam logic [3:0] S_STD  = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	logic [3:0]     state_q;
	logic           busy_q;
	wss_pkg::snap_t snap_q;

	logic [wss_pkg::MEAN_BITS-1:0] mean_mag_q;
	logic [wss_pkg::RAD_BITS-1:0]  msq_q;
	logic [wss_pkg::RAD_BITS-1:0]  msqm_q;
	logic [wss_pkg::OUT_BITS-1:0]  abs_q;
	logic [wss_pkg::IVL_BITS-1:0]  ivl_q;
	logic [wss_pkg::OUT_BITS-1:0]  rms_q;
	logic [wss_pkg::OUT_BITS-1:0]  std_q;
	logic                          out_valid_q;

	logic                          div_start;
	logic                          div_done;
	logic [wss_pkg::NUM_BITS-1:0]  div_num;
	logic [wss_pkg::CNT_BITS-1:0]  div_den;
	logic [wss_pkg::NUM_BITS-1:0]  quot;
	logic                          sq_start;
	logic                          sq_done;
	logic [wss_pkg::RAD_BITS-1:0]  sq_x;
	logic [wss_pkg::ROOT_BITS-1:0] root;
	logic [wss_pkg::SUM_BITS-1:0]  sum_mag;
	logic                          neg;
	logic [wss_pkg::OUT_BITS-1:0]  root_cap;
	logic                          zero_n;
	logic                          can_out;

	assign neg     = snap_q.vsum[wss_pkg::SUM_BITS-1];
	assign sum_mag = neg ? (~snap_q.vsum + 1'b1) : snap_q.vsum;
	assign zero_n  = (snap_q.count == '0);
	assign can_out = !out_valid_q || out_ready;
	assign pop     = (state_q == S_IDLE) && !empty;
	assign root_cap = (root > wss_pkg::ROOT_BITS'(wss_pkg::CAP31)) ? wss_pkg::CAP31
	                                                             : root[wss_pkg::OUT_BITS-1:0];

	always_comb begin
		div_num = '0;
		div_den = snap_q.count;
		case (state_q)
			S_MEAN: div_num = wss_pkg::NUM_BITS'(sum_mag) << wss_pkg::FRAC_BITS;
			S_MSQ:  div_num = wss_pkg::NUM_BITS'(snap_q.ssum) << (2*wss_pkg::FRAC_BITS);
			S_ABS:  div_num = wss_pkg::NUM_BITS'(snap_q.asum) << wss_pkg::FRAC_BITS;
			S_IVL: begin
				div_num = wss_pkg::NUM_BITS'(snap_q.latest_t - snap_q.first_t) << wss_pkg::FRAC_BITS;
				div_den = snap_q.count - 1'b1;
			end
			default: ;
		endcase
	end

	assign sq_x = (state_q == S_RMS) ? msq_q : ((msq_q > msqm_q) ? (msq_q - msqm_q) : '0);

	always_comb begin
		div_start = 1'b0;
		sq_start  = 1'b0;
		case (state_q)
			S_MEAN, S_MSQ, S_ABS: div_start = !busy_q;
			S_IVL: div_start = !busy_q && (snap_q.count > wss_pkg::CNT_BITS'(1));
			S_RMS, S_STD: sq_start = !busy_q;
			default: ;
		endcase
	end

	wss_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quot(quot)
	);

	wss_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .x(sq_x), .done(sq_done), .root(root)
	);

	always_ff @(posedge clk) begin
		if (pop) snap_q <= pop_data;
		if (div_done) begin
			case (state_q)
				S_MEAN: begin
					if (neg) mean_mag_q <= (quot > 80'h8000_0000) ? 32'h8000_0000
					                                               : quot[wss_pkg::MEAN_BITS-1:0];
					else mean_mag_q <= (quot > wss_pkg::NUM_BITS'(wss_pkg::CAP31))
					                   ? wss_pkg::MEAN_BITS'(wss_pkg::CAP31)
					                   : quot[wss_pkg::MEAN_BITS-1:0];
				end
				S_MSQ: msq_q <= (quot[wss_pkg::NUM_BITS-1:wss_pkg::RAD_BITS] != '0) ? '1
				                                                  : quot[wss_pkg::RAD_BITS-1:0];
				S_ABS: abs_q <= (quot > wss_pkg::NUM_BITS'(wss_pkg::CAP31)) ? wss_pkg::CAP31
				                                                  : quot[wss_pkg::OUT_BITS-1:0];
				S_IVL: ivl_q <= quot[wss_pkg::IVL_BITS-1:0];
				default: ;
			endcase
		end
		if (state_q == S_IVL && !busy_q && snap_q.count < wss_pkg::CNT_BITS'(2)) ivl_q <= '0;
		if (state_q == S_MUL) msqm_q <= mean_mag_q * mean_mag_q;
		if (sq_done && state_q == S_RMS) rms_q <= root_cap;
		if (sq_done && state_q == S_STD) std_q <= root_cap;
		if (state_q == S_DONE && can_out) begin
			sample_count   <= snap_q.count;
			count_overflow <= snap_q.dropped;
			min_value      <= zero_n ? '0 : snap_q.vmin;
			max_value      <= zero_n ? '0 : snap_q.vmax;
			value_span     <= zero_n ? '0 : (snap_q.vmax - snap_q.vmin);
			mean_value     <= zero_n ? '0 : (neg ? (~mean_mag_q + 1'b1) : mean_mag_q);
			rms_value      <= zero_n ? '0 : rms_q;
			std_deviation  <= zero_n ? '0 : std_q;
			abs_mean       <= zero_n ? '0 : abs_q;
			sample_spacing <= zero_n ? '0 : ivl_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && can_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (div_start || sq_start) busy_q <= 1'b1;
			case (state_q)
				S_IDLE: begin
					if (!empty) state_q <= (pop_data.count == '0) ? S_DONE : S_MEAN;
				end
				S_MEAN, S_MSQ, S_ABS: begin
					if (div_done) begin
						busy_q  <= 1'b0;
						state_q <= state_q + 4'd1;
					end
				end
				S_IVL: begin
					if (!busy_q && snap_q.count < wss_pkg::CNT_BITS'(2)) begin
						state_q <= S_MUL;
					end else if (div_done) begin
						busy_q  <= 1'b0;
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_RMS;
				S_RMS, S_STD: begin
					if (sq_done) begin
						busy_q  <= 1'b0;
						state_q <= state_q + 4'd1;
					end
				end
				S_DONE: begin
					if (can_out) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == S_IDLE))
		else $error("snapshot taken while busy");
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !busy_q)
		else $error("divider restarted while busy");
	a_done_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && can_out) |=> out_valid)
		else $error("result not presented");

endmodule

// ----- sv/windowed_series_statistics.sv -----
// Top level of the windowed series statistics block.
// Instantiates wss_front, wss_fifo and wss_back; uses wss_pkg.
//
// Channel   Direction  Handshake              Payload
// in        in         in_valid / in_ready    sample_time, sample_value, last_sample
// out       out        out_valid / out_ready  sample_count .. count_overflow
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Samples are taken one per cycle while the queue is not full; accumulation is done in the
// front end in the cycle of the transfer. A result takes four divisions, two square roots
// and sequencing states in the back end; one sample skips the spacing division, none skips all.
// Two finished series can wait in the queue; input stalls only while both are occupied.
// arst_n clears the accumulator and control state; configuration resets to window on, start 0, end all ones.
module windowed_series_statistics (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [wss_pkg::TIME_BITS-1:0]         sample_time,
	input  logic signed [wss_pkg::VALUE_BITS-1:0] sample_value,
	input  logic                                  last_sample,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [1:0]                            cfg_index,
	input  logic [wss_pkg::TIME_BITS-1:0]         cfg_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [wss_pkg::CNT_BITS-1:0]          sample_count,
	output logic signed [wss_pkg::VALUE_BITS-1:0] min_value,
	output logic signed [wss_pkg::VALUE_BITS-1:0] max_value,
	output logic [wss_pkg::VALUE_BITS-1:0]        value_span,
	output logic signed [wss_pkg::MEAN_BITS-1:0]  mean_value,
	output logic [wss_pkg::OUT_BITS-1:0]          rms_value,
	output logic [wss_pkg::OUT_BITS-1:0]          std_deviation,
	output logic [wss_pkg::OUT_BITS-1:0]          abs_mean,
	output logic [wss_pkg::IVL_BITS-1:0]          sample_spacing,
	output logic                                  count_overflow
);

	logic           push;
	logic           pop;
	logic           full;
	logic           empty;
	wss_pkg::snap_t push_data;
	wss_pkg::snap_t pop_data;

	wss_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.sample_time(sample_time), .sample_value(sample_value), .last_sample(last_sample),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .push(push), .push_data(push_data), .full(full)
	);

	wss_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data), .pop(pop),
		.pop_data(pop_data), .full(full), .empty(empty)
	);

	wss_back u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .pop_data(pop_data), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready), .sample_count(sample_count),
		.min_value(min_value), .max_value(max_value), .value_span(value_span),
		.mean_value(mean_value), .rms_value(rms_value), .std_deviation(std_deviation),
		.abs_mean(abs_mean), .sample_spacing(sample_spacing),
		.count_overflow(count_overflow)
	);

endmodule

// ----- tb/sv/windowed_series_statistics_test.sv -----
// Self-checking testbench for windowed_series_statistics: directed and random series
// against a behavioral predictor. Depends on wss_pkg and the block's RTL only.
`timescale 1ns / 1ps

module windowed_series_statistics_test;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam longint unsigned TMAX = 64'hFFFF_FFFF_FFFF;
	localparam longint unsigned CAP = 64'h7FFF_FFFF;

	typedef struct {
		logic [wss_pkg::TIME_BITS-1:0]         ts;
		logic signed [wss_pkg::VALUE_BITS-1:0] val;
		logic                                  last;
	} sample_t;

	typedef struct {
		logic [wss_pkg::CNT_BITS-1:0]          cnt;
		logic signed [wss_pkg::VALUE_BITS-1:0] vmin;
		logic signed [wss_pkg::VALUE_BITS-1:0] vmax;
		logic [wss_pkg::VALUE_BITS-1:0]        p2p;
		logic signed [wss_pkg::MEAN_BITS-1:0]  mean;
		logic [wss_pkg::OUT_BITS-1:0]          rms;
		logic [wss_pkg::OUT_BITS-1:0]          sdev;
		logic [wss_pkg::OUT_BITS-1:0]          mabs;
		logic [wss_pkg::IVL_BITS-1:0]          ivl;
		logic                                  ovf;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [wss_pkg::TIME_BITS-1:0] sample_time = '0;
	logic signed [wss_pkg::VALUE_BITS-1:0] sample_value = '0;
	logic last_sample = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = wss_pkg::CFG_ENABLE;
	logic [wss_pkg::TIME_BITS-1:0] cfg_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [wss_pkg::CNT_BITS-1:0] sample_count;
	logic signed [wss_pkg::VALUE_BITS-1:0] min_value, max_value;
	logic [wss_pkg::VALUE_BITS-1:0] value_span;
	logic signed [wss_pkg::MEAN_BITS-1:0] mean_value;
	logic [wss_pkg::OUT_BITS-1:0] rms_value, std_deviation, abs_mean;
	logic [wss_pkg::IVL_BITS-1:0] sample_spacing;
	logic count_overflow;

	windowed_series_statistics dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sample_t pending_samples[$];
	stats_t expected_stats[$];
	int mismatches = 0;
	bit quiet = 1'b0;
	int idle_cycles = 0;

	// register copies
	bit win_en = 1'b1;
	longint unsigned win_start = 0, win_end = TMAX;

	// series accumulator
	longint unsigned acc_cnt, acc_first, acc_latest, acc_sq, acc_abs;
	longint acc_min, acc_max, acc_sum;
	bit acc_past, acc_dropped;

	function automatic longint unsigned fixed_div(longint unsigned num, longint unsigned den,
			int fb, longint unsigned cap);
		longint unsigned q, r, res;
		if (den == 0) return 0;
		q = num / den;
		r = num % den;
		if (q > (cap >> fb)) return cap;
		res = q << fb;
		for (int i = fb; i > 0; i--) begin
			r = r << 1;
			if (r >= den) begin
				r -= den;
				res |= 64'd1 << (i - 1);
			end
		end
		return (res > cap) ? cap : res;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned x);
		longint unsigned res = 0, b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x -= res + b;
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	task automatic clear_series();
		acc_cnt = 0; acc_first = 0; acc_latest = 0; acc_sq = 0; acc_abs = 0;
		acc_min = 0; acc_max = 0; acc_sum = 0; acc_past = 0; acc_dropped = 0;
	endtask

	task automatic accumulate_sample(sample_t s);
		longint v, mean_s;
		longint unsigned t, mag, mean_mag, msq, var_fx, r;
		bit take;
		stats_t e;
		v = s.val;
		t = s.ts;
		take = 1'b1;
		if (win_en) begin
			if (acc_past) take = 1'b0;
			else if (t < win_start) take = 1'b0;
			else if (t > win_end) begin
				acc_past = 1'b1;
				take = 1'b0;
			end
		end
		if (take) begin
			if (acc_cnt >= 65536) acc_dropped = 1'b1;
			else begin
				if (acc_cnt == 0) begin
					acc_first = t; acc_latest = t; acc_min = v; acc_max = v;
				end else begin
					if (t < acc_first) acc_first = t;
					if (t > acc_latest) acc_latest = t;
					if (v < acc_min) acc_min = v;
					if (v > acc_max) acc_max = v;
				end
				acc_cnt++;
				acc_sum += v;
				mag = (v < 0) ? -v : v;
				acc_sq += mag * mag;
				acc_abs += mag;
			end
		end
		if (!s.last) return;
		e = '{default: '0};
		e.cnt = wss_pkg::CNT_BITS'(acc_cnt);
		e.ovf = acc_dropped;
		if (acc_cnt != 0) begin
			e.vmin = wss_pkg::VALUE_BITS'(acc_min);
			e.vmax = wss_pkg::VALUE_BITS'(acc_max);
			e.p2p = wss_pkg::VALUE_BITS'(acc_max - acc_min);
			if (acc_sum < 0) begin
				mean_mag = fixed_div(-acc_sum, acc_cnt, wss_pkg::FRAC_BITS, CAP + 1);
				mean_s = -mean_mag;
			end else begin
				mean_mag = fixed_div(acc_sum, acc_cnt, wss_pkg::FRAC_BITS, CAP);
				mean_s = mean_mag;
			end
			e.mean = wss_pkg::MEAN_BITS'(mean_s);
			msq = fixed_div(acc_sq, acc_cnt, 2 * wss_pkg::FRAC_BITS, 64'hFFFF_FFFF_FFFF_FFFF);
			r = floor_sqrt(msq);
			e.rms = wss_pkg::OUT_BITS'((r > CAP) ? CAP : r);
			var_fx = (msq > mean_mag * mean_mag) ? msq - mean_mag * mean_mag : 0;
			r = floor_sqrt(var_fx);
			e.sdev = wss_pkg::OUT_BITS'((r > CAP) ? CAP : r);
			e.mabs = wss_pkg::OUT_BITS'(fixed_div(acc_abs, acc_cnt, wss_pkg::FRAC_BITS, CAP));
			if (acc_cnt >= 2)
				e.ivl = wss_pkg::IVL_BITS'(fixed_div(acc_latest - acc_first, acc_cnt - 1,
					wss_pkg::FRAC_BITS, 64'h00FF_FFFF_FFFF_FFFF));
		end
		expected_stats.push_back(e);
		clear_series();
	endtask

	task automatic check_field(string name, longint unsigned want, longint unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch %s: expected %h, got %h", name, want, got);
		end
	endtask

	// sender
	int in_gap = 0;
	always @(posedge clk or negedge arst_n) begin : sender
		sample_t s;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!(in_valid && !in_ready)) begin
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_samples.size() > 0) begin
				s = pending_samples.pop_front();
				sample_time <= s.ts;
				sample_value <= s.val;
				last_sample <= s.last;
				in_valid <= 1'b1;
				if (!quiet && $urandom_range(0, 11) == 0) in_gap = $urandom_range(1, 8);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stalls
	int out_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_gap > 0) begin
			out_gap--;
			out_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			out_gap = $urandom_range(0, 7);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// monitor, predictor and watchdog
	always @(posedge clk) begin : monitor
		stats_t e;
		if (arst_n) begin
			idle_cycles++;
			if (cfg_valid && cfg_ready) idle_cycles = 0;
			if (in_valid && in_ready) begin
				idle_cycles = 0;
				accumulate_sample('{sample_time, sample_value, last_sample});
			end
			if (out_valid && out_ready) begin
				idle_cycles = 0;
				if (expected_stats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("result with no series pending");
				end else begin
					e = expected_stats.pop_front();
					check_field("sample_count", e.cnt, sample_count);
					check_field("min_value", e.vmin[23:0], min_value[23:0]);
					check_field("max_value", e.vmax[23:0], max_value[23:0]);
					check_field("value_span", e.p2p, value_span);
					check_field("mean_value", e.mean[31:0], mean_value[31:0]);
					check_field("rms_value", e.rms, rms_value);
					check_field("std_deviation", e.sdev, std_deviation);
					check_field("abs_mean", e.mabs, abs_mean);
					check_field("sample_spacing", e.ivl, sample_spacing);
					check_field("count_overflow", e.ovf, count_overflow);
				end
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, longint unsigned data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data[47:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			wss_pkg::CFG_ENABLE: win_en = data[0];
			wss_pkg::CFG_START:  win_start = data & TMAX;
			default:             win_end = data & TMAX;
		endcase
	endtask

	// holds off the next test step until all samples are sent and all results are back
	task automatic drain();
		while (pending_samples.size() != 0 || in_valid || expected_stats.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic push(longint unsigned ts, longint v, bit last);
		sample_t s;
		s.ts = ts[47:0];
		s.val = v[23:0];
		s.last = last;
		pending_samples.push_back(s);
	endtask

	task automatic random_series(int n_series, longint unsigned lo, longint unsigned span);
		int len;
		longint unsigned ts;
		logic [23:0] v;
		for (int k = 0; k < n_series; k++) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 3) == 0) ts = {$urandom, $urandom} & TMAX;
				else ts = (lo + ({$urandom, $urandom} % (span + 1))) & TMAX;
				case ($urandom_range(0, 7))
					0: v = 24'h7FFFFF;
					1: v = 24'h800000;
					2: v = 24'($urandom_range(0, 255));
					default: v = 24'($urandom);
				endcase
				push(ts, $signed(v), i == len - 1);
			end
		end
	endtask

	initial begin
		clear_series();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// default window: everything included
		push(0, 8388607, 1);
		push(TMAX, -8388608, 1);
		push(500, 0, 0);
		push(100, -8388608, 0);
		push(TMAX, 8388607, 0);
		push(300, -1, 1);
		push(7, 5, 0);
		push(7, 5, 1);
		random_series(20, 0, TMAX);
		drain();

		write_reg(wss_pkg::CFG_START, 1000);
		write_reg(wss_pkg::CFG_END, 2000);
		push(999, 77, 0);
		push(1000, -3, 0);
		push(2000, 12, 0);
		push(2001, 500, 0);
		push(1500, 900, 1);
		push(10, 1, 0);
		push(20, 2, 1);
		push(5000, 4, 1);
		random_series(25, 900, 1200);
		drain();

		write_reg(wss_pkg::CFG_ENABLE, 0);
		push(5000, 4, 0);
		push(10, -9, 1);
		random_series(20, 900, 1200);
		drain();

		write_reg(wss_pkg::CFG_ENABLE, 1);
		write_reg(wss_pkg::CFG_START, 0);
		write_reg(wss_pkg::CFG_END, 0);
		push(0, 3, 0);
		push(1, 4, 0);
		push(0, 5, 1);
		random_series(15, 0, 3);
		drain();

		write_reg(wss_pkg::CFG_START, TMAX);
		write_reg(wss_pkg::CFG_END, TMAX);
		push(TMAX - 1, 6, 0);
		push(TMAX, -7, 1);
		random_series(15, TMAX - 2, 2);
		drain();

		quiet = 1'b1;
		write_reg(wss_pkg::CFG_ENABLE, 1);
		write_reg(wss_pkg::CFG_START, 100);
		write_reg(wss_pkg::CFG_END, 64'h10000);
		random_series(25, 50, 64'h10100);
		drain();
		repeat (400) @(posedge clk);

		if (mismatches == 0 && expected_stats.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- windowed_series_statistics.f -----
sv/wss_pkg.sv
sv/wss_front.sv
sv/wss_fifo.sv
sv/wss_div.sv
sv/wss_sqrt.sv
sv/wss_back.sv
sv/windowed_series_statistics.sv
tb/sv/windowed_series_statistics_test.sv
